/* design/rths_pkg.sv */
`timescale 1ns / 1ps
package rths_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int HIST_BINS     = 1024;
   localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
   localparam int BIN_AW        = $clog2(HIST_BINS);
   localparam int CNT_W         = 48;
   localparam int OCC_W         = TBL_AW + 1;

   localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
   localparam logic [TBL_AW-1:0] TBL_LAST   = TBL_AW'(TABLE_ENTRIES - 1);
   localparam logic [BIN_AW-1:0] BIN_LAST   = BIN_AW'(HIST_BINS - 1);
   localparam logic [BIN_AW:0]   BIN_LIMIT  = (BIN_AW + 1)'(HIST_BINS);
   localparam logic [OCC_W-1:0]  OCC_LIMIT  = OCC_W'(TABLE_ENTRIES);

   // configuration register indexes
   localparam logic [1:0] CSR_SAMPLE_RATE  = 2'd0;
   localparam logic [1:0] CSR_GROUP_SIZE   = 2'd1;
   localparam logic [1:0] CSR_FIRST_SAMPLE = 2'd2;

   // operation codes
   localparam logic OP_ACCESS   = 1'b0;
   localparam logic OP_READ_BIN = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [63:0] access_key;
      logic [30:0] random_draw;
      logic [9:0]  bin_select;
   } req_type;

   typedef struct packed {
      logic [47:0] bin_count;
      logic        reuse_found;
      logic [9:0]  reuse_bin;
      logic        sample_taken;
      logic        sample_dropped;
      logic [47:0] accesses_total;
      logic [47:0] reuses_total;
      logic [10:0] occupancy;
      logic [10:0] peak_occupancy;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [63:0]      key;
      logic [CNT_W-1:0] stamp;
   } tbl_entry_type;

endpackage

/* design/rths_bucket.sv */
`timescale 1ns / 1ps
module rths_bucket
   import rths_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CNT_W-1:0]  value,
   input  logic [8:0]        group_size,
   output logic              done,
   output logic [BIN_AW-1:0] bin
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [59:0]       base_ff, base_in;
   logic [5:0]        shift_ff, shift_in;
   logic [BIN_AW:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]  val_ff, val_in;
   logic [8:0]        grp_ff, grp_in;
   logic [BIN_AW-1:0] bin_ff, bin_in;

   logic [59:0]     step;
   logic [60:0]     sum;
   logic [BIN_AW:0] idx_next;
   logic [48:0]     diff_up;
   logic [48:0]     quot;
   logic [BIN_AW:0] idx_fin;

   always_comb begin
      step     = {51'b0, grp_ff} << shift_ff;
      sum      = {1'b0, base_ff} + {1'b0, step};
      idx_next = idx_ff + {{(BIN_AW - 8){1'b0}}, grp_ff};
      // ceiling of the remainder over the current bucket width
      diff_up  = {1'b0, val_ff - base_ff[CNT_W-1:0]} + ((49'd1 << shift_ff) - 49'd1);
      quot     = diff_up >> shift_ff;
      idx_fin  = (val_ff > base_ff[CNT_W-1:0]) ? idx_ff + quot[BIN_AW:0] : idx_ff;

      run_in   = run_ff;
      done_in  = 1'b0;
      base_in  = base_ff;
      shift_in = shift_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      grp_in   = grp_ff;
      bin_in   = bin_ff;

      if (start) begin
         run_in   = 1'b1;
         base_in  = '0;
         shift_in = '0;
         idx_in   = '0;
         val_in   = value;
         grp_in   = group_size;
      end else if (run_ff) begin
         if (sum < {13'b0, val_ff}) begin
            base_in  = sum[59:0];
            shift_in = shift_ff + 6'd1;
            idx_in   = idx_next;
            if (idx_next >= BIN_LIMIT) begin
               bin_in  = BIN_LAST;
               run_in  = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            bin_in  = (idx_fin >= BIN_LIMIT) ? BIN_LAST : idx_fin[BIN_AW-1:0];
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      base_ff  <= base_in;
      shift_ff <= shift_in;
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      grp_ff   <= grp_in;
      bin_ff   <= bin_in;
   end

   assign done = done_ff;
   assign bin  = bin_ff;

endmodule

/* design/reuse_time_histogram_sampler_top.sv */
`timescale 1ns / 1ps
// sampled reuse-time histogram
// req channel: one word per item, operation access or read-bin; accepted when
// req_valid is high and req_stall low. req_stall is high whenever the block is
// busy with an item, so only one item is in work at a time.
// rsp channel: exactly one word per item in a register; a new item may be
// accepted while that word waits under rsp_stall, but the next result waits
// in the final state until the register frees up.
// sequence: a read-bin item passes through the read and final states, its word
// registered when it leaves the final state. an access walks the sample table one
// entry per cycle through the table memory port (it stops at a match); with no
// match it goes on to the check and final states. a reuse first passes through
// the bucket unit, whose iterations step over the groups, and the histogram read
// and write states before the check; a sample adds the bit-serial spacing
// remainder and the table write.
// csr port: plain writes of sample rate, group size and first sample position;
// the user must make them only while idle, the block does not enforce it; the
// last also reloads the sample position. reset: synchronous; then a clearing
// pass over 1024 entries zeroes table and histogram, req_stall high throughout.
module reuse_time_histogram_sampler_top
   import rths_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);

   typedef enum logic [10:0] {
      ST_CLEAR   = 11'b00000000001,
      ST_IDLE    = 11'b00000000010,
      ST_SCAN    = 11'b00000000100,
      ST_BUCKET  = 11'b00000001000,
      ST_HIST_RD = 11'b00000010000,
      ST_HIST_WR = 11'b00000100000,
      ST_CHECK   = 11'b00001000000,
      ST_MOD     = 11'b00010000000,
      ST_SAMPLE  = 11'b00100000000,
      ST_READ    = 11'b01000000000,
      ST_DONE    = 11'b10000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [TBL_AW-1:0] clr_idx_ff, clr_idx_in;
   logic [15:0]       rate_ff, rate_in;
   logic [8:0]        grp_ff, grp_in;
   logic [CNT_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  reuse_ff, reuse_in;
   logic [CNT_W-1:0]  next_ff, next_in;
   logic [OCC_W-1:0]  count_ff, count_in;
   logic [OCC_W-1:0]  peak_ff, peak_in;
   logic              op_ff, op_in;
   logic [63:0]       key_ff, key_in;
   logic [30:0]       draw_ff, draw_in;
   logic [BIN_AW-1:0] sel_ff, sel_in;
   logic [TBL_AW-1:0] scan_addr_ff, scan_addr_in;
   logic              pend_ff, pend_in;
   logic [TBL_AW-1:0] pend_idx_ff, pend_idx_in;
   logic              free_ok_ff, free_ok_in;
   logic [TBL_AW-1:0] free_idx_ff, free_idx_in;
   logic              found_ff, found_in;
   logic [BIN_AW-1:0] rbin_ff, rbin_in;
   logic              taken_ff, taken_in;
   logic              dropped_ff, dropped_in;
   logic [16:0]       mod_rem_ff, mod_rem_in;
   logic [4:0]        mod_cnt_ff, mod_cnt_in;
   logic [16:0]       mod_m_ff, mod_m_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   tbl_entry_type     tbl_mem [TABLE_ENTRIES];
   tbl_entry_type     tbl_q_ff;
   logic              tbl_we;
   logic [TBL_AW-1:0] tbl_waddr;
   tbl_entry_type     tbl_wdata;

   logic [CNT_W-1:0]  hist_mem [HIST_BINS];
   logic [CNT_W-1:0]  hist_q_ff;
   logic              hist_we;
   logic [BIN_AW-1:0] hist_waddr;
   logic [CNT_W-1:0]  hist_wdata;
   logic              hist_re;
   logic [BIN_AW-1:0] hist_raddr;

   logic              bkt_start;
   logic [CNT_W-1:0]  bkt_value;
   logic [8:0]        bkt_group;
   logic              bkt_done;
   logic [BIN_AW-1:0] bkt_bin;

   logic              req_accept;
   logic [15:0]       rate_eff;
   logic [17:0]       rem_sh;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign rate_eff   = (rate_ff == 16'd0) ? 16'd1 : rate_ff;
   assign bkt_group  = (grp_ff == 9'd0) ? 9'd1 : grp_ff;
   assign bkt_value  = acc_ff - tbl_q_ff.stamp;
   assign rem_sh     = {mod_rem_ff, draw_ff[mod_cnt_ff]};

   rths_bucket u_bucket (
      .clock      (clock),
      .reset      (reset),
      .start      (bkt_start),
      .value      (bkt_value),
      .group_size (bkt_group),
      .done       (bkt_done),
      .bin        (bkt_bin)
   );

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      rate_in      = rate_ff;
      grp_in       = grp_ff;
      acc_in       = acc_ff;
      reuse_in     = reuse_ff;
      next_in      = next_ff;
      count_in     = count_ff;
      peak_in      = peak_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      draw_in      = draw_ff;
      sel_in       = sel_ff;
      scan_addr_in = scan_addr_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      found_in     = found_ff;
      rbin_in      = rbin_ff;
      taken_in     = taken_ff;
      dropped_in   = dropped_ff;
      mod_rem_in   = mod_rem_ff;
      mod_cnt_in   = mod_cnt_ff;
      mod_m_in     = mod_m_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      tbl_we       = 1'b0;
      tbl_waddr    = pend_idx_ff;
      tbl_wdata    = tbl_q_ff;
      hist_we      = 1'b0;
      hist_waddr   = rbin_ff;
      hist_wdata   = (hist_q_ff == CNT_MAX) ? hist_q_ff : hist_q_ff + 48'd1;
      hist_re      = 1'b0;
      hist_raddr   = rbin_ff;
      bkt_start    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            tbl_we     = 1'b1;
            tbl_waddr  = clr_idx_ff;
            tbl_wdata  = '0;
            hist_we    = 1'b1;
            hist_waddr = clr_idx_ff;
            hist_wdata = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == TBL_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               op_in        = req_data.operation;
               key_in       = req_data.access_key;
               draw_in      = req_data.random_draw;
               sel_in       = req_data.bin_select;
               found_in     = 1'b0;
               rbin_in      = '0;
               taken_in     = 1'b0;
               dropped_in   = 1'b0;
               scan_addr_in = '0;
               pend_in      = 1'b0;
               free_ok_in   = 1'b0;
               if (req_data.operation == OP_READ_BIN) begin
                  state_in = ST_READ;
               end else begin
                  acc_in   = acc_ff + 48'd1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // one table word read per cycle, compared in the following cycle
            scan_addr_in = scan_addr_ff + 1'b1;
            pend_in      = 1'b1;
            pend_idx_in  = scan_addr_ff;
            if (pend_ff) begin
               if (tbl_q_ff.valid && (tbl_q_ff.key == key_ff)) begin
                  tbl_we          = 1'b1;
                  tbl_wdata.valid = 1'b0;
                  found_in        = 1'b1;
                  count_in        = (count_ff != '0) ? count_ff - 1'b1 : count_ff;
                  // freed entry is the lowest free one unless an earlier was seen
                  if (!free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = pend_idx_ff;
                  end
                  bkt_start = 1'b1;
                  state_in  = ST_BUCKET;
               end else begin
                  if (!tbl_q_ff.valid && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = pend_idx_ff;
                  end
                  if (pend_idx_ff == TBL_LAST) begin
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_BUCKET: begin
            if (bkt_done) begin
               rbin_in  = bkt_bin;
               state_in = ST_HIST_RD;
            end
         end
         ST_HIST_RD: begin
            hist_re  = 1'b1;
            state_in = ST_HIST_WR;
         end
         ST_HIST_WR: begin
            hist_we  = 1'b1;
            reuse_in = reuse_ff + 48'd1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (acc_ff == next_ff) begin
               mod_rem_in = '0;
               mod_cnt_in = 5'd30;
               mod_m_in   = {rate_eff, 1'b0};
               state_in   = ST_MOD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MOD: begin
            // restoring remainder, one draw bit per cycle
            if (rem_sh >= {1'b0, mod_m_ff}) begin
               mod_rem_in = 17'(rem_sh - {1'b0, mod_m_ff});
            end else begin
               mod_rem_in = rem_sh[16:0];
            end
            mod_cnt_in = mod_cnt_ff - 5'd1;
            if (mod_cnt_ff == 5'd0) begin
               state_in = ST_SAMPLE;
            end
         end
         ST_SAMPLE: begin
            next_in = next_ff + {31'b0, mod_rem_ff} + 48'd1;
            if ((count_ff < OCC_LIMIT) && free_ok_ff) begin
               tbl_we          = 1'b1;
               tbl_waddr       = free_idx_ff;
               tbl_wdata.valid = 1'b1;
               tbl_wdata.key   = key_ff;
               tbl_wdata.stamp = acc_ff;
               count_in        = count_ff + 1'b1;
               taken_in        = 1'b1;
            end else begin
               dropped_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_READ: begin
            hist_re    = 1'b1;
            hist_raddr = sel_ff;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (op_ff == OP_ACCESS && count_ff > peak_ff) begin
               peak_in = count_ff;
            end
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_in.bin_count      = (op_ff == OP_READ_BIN) ? hist_q_ff : '0;
               rsp_in.reuse_found    = found_ff;
               rsp_in.reuse_bin      = rbin_ff;
               rsp_in.sample_taken   = taken_ff;
               rsp_in.sample_dropped = dropped_ff;
               rsp_in.accesses_total = acc_ff;
               rsp_in.reuses_total   = reuse_ff;
               rsp_in.occupancy      = count_ff;
               rsp_in.peak_occupancy = peak_in;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         case (csr_index)
            CSR_SAMPLE_RATE:  rate_in = csr_data[15:0];
            CSR_GROUP_SIZE:   grp_in  = csr_data[8:0];
            CSR_FIRST_SAMPLE: next_in = {31'b0, csr_data};
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rate_ff      <= 16'd64;
         grp_ff       <= 9'd32;
         acc_ff       <= '0;
         reuse_ff     <= '0;
         next_ff      <= 48'd1;
         count_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         free_ok_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rate_ff      <= rate_in;
         grp_ff       <= grp_in;
         acc_ff       <= acc_in;
         reuse_ff     <= reuse_in;
         next_ff      <= next_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         free_ok_ff   <= free_ok_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      draw_ff      <= draw_in;
      sel_ff       <= sel_in;
      scan_addr_ff <= scan_addr_in;
      pend_idx_ff  <= pend_idx_in;
      free_idx_ff  <= free_idx_in;
      found_ff     <= found_in;
      rbin_ff      <= rbin_in;
      taken_ff     <= taken_in;
      dropped_ff   <= dropped_in;
      mod_rem_ff   <= mod_rem_in;
      mod_cnt_ff   <= mod_cnt_in;
      mod_m_ff     <= mod_m_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_q_ff <= tbl_mem[scan_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (hist_re) begin
         hist_q_ff <= hist_mem[hist_raddr];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OCC_LIMIT)
      else $error("occupancy above table size");

   a_peak_covers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (peak_ff >= count_ff))
      else $error("peak below occupancy when idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside final state");

   a_take_or_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !(taken_ff && dropped_ff))
      else $error("sample both taken and dropped");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import rths_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_SAMPLE_RATE;
   logic [16:0] csr_data = '0;

   reuse_time_histogram_sampler_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   initial begin
      #150_000_000;
      $display("Verification failed");
      $finish;
   end

   // predicted block state
   logic [15:0]      rate_reg = 16'd64;
   logic [8:0]       group_reg = 9'd32;
   logic [CNT_W-1:0] access_count = '0;
   logic [CNT_W-1:0] next_sample = 48'd1;
   logic [63:0]      held_key [TABLE_ENTRIES];
   logic [CNT_W-1:0] held_stamp [TABLE_ENTRIES];
   bit               held_live [TABLE_ENTRIES];
   logic [CNT_W-1:0] hist [HIST_BINS];
   logic [CNT_W-1:0] reuse_count = '0;
   logic [10:0]      occ = '0;
   logic [10:0]      occ_peak = '0;
   logic [63:0]      sampled_keys [$];

   rsp_type expected_words [$];
   int      failures = 0;
   int      rsp_hold = 0;

   initial begin
      for (int i = 0; i < HIST_BINS; i++) hist[i] = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) held_live[i] = 1'b0;
   end

   function automatic logic [BIN_AW-1:0] reuse_bucket(logic [CNT_W-1:0] gap);
      longint unsigned d, base, width, idx, v;
      v = gap;
      d = (group_reg == 0) ? 1 : group_reg;
      base = 0;
      width = 1;
      idx = 0;
      while (base + width * d < v) begin
         base += width * d;
         width <<= 1;
         idx += d;
         if (idx >= HIST_BINS) return BIN_LAST;
      end
      if (v > base) idx += (v - base + width - 1) / width;
      if (idx >= HIST_BINS) idx = HIST_BINS - 1;
      return idx[BIN_AW-1:0];
   endfunction

   function automatic rsp_type predict_word(req_type w);
      rsp_type r;
      longint unsigned span;
      r = '0;
      if (w.operation == OP_READ_BIN) begin
         r.bin_count = hist[w.bin_select];
      end else begin
         access_count = access_count + 1'b1;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (held_live[i] && held_key[i] == w.access_key) begin
               r.reuse_bin = reuse_bucket(access_count - held_stamp[i]);
               if (hist[r.reuse_bin] != CNT_MAX) hist[r.reuse_bin]++;
               reuse_count = reuse_count + 1'b1;
               held_live[i] = 1'b0;
               if (occ > 0) occ--;
               r.reuse_found = 1'b1;
               break;
            end
         end
         if (access_count == next_sample) begin
            span = 2 * ((rate_reg == 0) ? 1 : rate_reg);
            if (occ < OCC_LIMIT) begin
               for (int i = 0; i < TABLE_ENTRIES; i++) begin
                  if (!held_live[i]) begin
                     held_live[i] = 1'b1;
                     held_key[i] = w.access_key;
                     held_stamp[i] = access_count;
                     occ++;
                     r.sample_taken = 1'b1;
                     sampled_keys.push_back(w.access_key);
                     if (sampled_keys.size() > 64) sampled_keys.delete(0);
                     break;
                  end
               end
            end
            r.sample_dropped = !r.sample_taken;
            next_sample = next_sample + CNT_W'(longint'(w.random_draw) % span + 1);
         end
         if (occ > occ_peak) occ_peak = occ;
      end
      r.accesses_total = access_count;
      r.reuses_total = reuse_count;
      r.occupancy = occ;
      r.peak_occupancy = occ_peak;
      return r;
   endfunction

   task automatic check_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
         $error("%s mismatch: expected %0h, actual %0h", name, e, a);
         failures++;
      end
   endtask

   // result side: random stall and comparison against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word %h", rsp_data);
            failures++;
         end else begin
            rsp_type e;
            e = expected_words.pop_front();
            check_field("bin_count", e.bin_count, rsp_data.bin_count);
            check_field("reuse_found", e.reuse_found, rsp_data.reuse_found);
            check_field("reuse_bin", e.reuse_bin, rsp_data.reuse_bin);
            check_field("sample_taken", e.sample_taken, rsp_data.sample_taken);
            check_field("sample_dropped", e.sample_dropped, rsp_data.sample_dropped);
            check_field("accesses_total", e.accesses_total, rsp_data.accesses_total);
            check_field("reuses_total", e.reuses_total, rsp_data.reuses_total);
            check_field("occupancy", e.occupancy, rsp_data.occupancy);
            check_field("peak_occupancy", e.peak_occupancy, rsp_data.peak_occupancy);
         end
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
      end else begin
         int p;
         p = $urandom_range(0, 99);
         if (p < 60) begin
            rsp_stall <= 1'b0;
            rsp_hold = $urandom_range(0, 20);
         end else if (p < 95) begin
            rsp_stall <= 1'b1;
            rsp_hold = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            rsp_hold = $urandom_range(10, 60);
         end
      end
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 0;
      if (p < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 50);
   endfunction

   // holds the word until accepted; when fixed is set, fixed_word overrides the prediction
   task automatic send_word(req_type w, bit fixed, rsp_type fixed_word);
      rsp_type p;
      int g;
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      p = predict_word(w);
      expected_words.push_back(fixed ? fixed_word : p);
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_settings(logic [16:0] rate, logic [16:0] group,
                                 logic [16:0] first);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= CSR_SAMPLE_RATE;
      csr_data <= rate;
      @(posedge clock);
      csr_index <= CSR_GROUP_SIZE;
      csr_data <= group;
      @(posedge clock);
      csr_index <= CSR_FIRST_SAMPLE;
      csr_data <= first;
      @(posedge clock);
      csr_write <= 1'b0;
      rate_reg = rate[15:0];
      group_reg = group[8:0];
      next_sample = CNT_W'(first);
   endtask

   function automatic req_type access_word(logic [63:0] key, logic [30:0] draw);
      return '{OP_ACCESS, key, draw, 10'd0};
   endfunction

   function automatic req_type read_word(logic [9:0] sel);
      return '{OP_READ_BIN, {$urandom, $urandom}, 31'($urandom), sel};
   endfunction

   function automatic req_type random_word(int read_pct, int reuse_pct);
      logic [63:0] key;
      logic [30:0] draw;
      int j;
      if ($urandom_range(0, 99) < read_pct)
         return read_word(($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 40))
                                                      : 10'($urandom));
      if ($urandom_range(0, 99) < reuse_pct && occ != 0) begin
         if (occ > 512) begin
            do j = $urandom_range(0, TABLE_ENTRIES - 1); while (!held_live[j]);
            key = held_key[j];
         end else if (sampled_keys.size() != 0) begin
            key = sampled_keys[$urandom_range(0, sampled_keys.size() - 1)];
         end else begin
            key = 64'($urandom_range(0, 15));
         end
      end else if ($urandom_range(0, 1) != 0) begin
         key = 64'($urandom_range(0, 15));
      end else begin
         key = {$urandom, $urandom};
      end
      draw = ($urandom_range(0, 1) != 0) ? 31'($urandom_range(0, 7)) : 31'($urandom);
      return access_word(key, draw);
   endfunction

   task automatic run_random(int n, int read_pct, int reuse_pct);
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) wait_idle();
         send_word(random_word(read_pct, reuse_pct), 1'b0, '0);
      end
   endtask

   typedef struct {
      req_type w;
      bit      fixed;
      rsp_type e;
   } stim_row;

   stim_row rows [$];

   initial begin
      int drops;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // known answers from reset settings: rate 64, group 32, first sample at 1
      rows.push_back('{read_word(10'd0), 1'b1, '{48'd0, 1'b0, 10'd0, 1'b0, 1'b0,
                       48'd0, 48'd0, 11'd0, 11'd0}});
      rows.push_back('{access_word(64'd0, 31'd0), 1'b1, '{48'd0, 1'b0, 10'd0, 1'b1,
                       1'b0, 48'd1, 48'd0, 11'd1, 11'd1}});
      rows.push_back('{access_word({64{1'b1}}, {31{1'b1}}), 1'b1, '{48'd0, 1'b0, 10'd0,
                       1'b1, 1'b0, 48'd2, 48'd0, 11'd2, 11'd2}});
      rows.push_back('{access_word(64'd0, 31'd5), 1'b1, '{48'd0, 1'b1, 10'd2, 1'b0,
                       1'b0, 48'd3, 48'd1, 11'd1, 11'd2}});
      rows.push_back('{read_word(10'd2), 1'b1, '{48'd1, 1'b0, 10'd0, 1'b0, 1'b0,
                       48'd3, 48'd1, 11'd1, 11'd2}});
      rows.push_back('{read_word(10'h3FF), 1'b1, '{48'd0, 1'b0, 10'd0, 1'b0, 1'b0,
                       48'd3, 48'd1, 11'd1, 11'd2}});
      rows.push_back('{access_word({64{1'b1}}, 31'd0), 1'b1, '{48'd0, 1'b1, 10'd2, 1'b0,
                       1'b0, 48'd4, 48'd2, 11'd0, 11'd2}});
      rows.push_back('{read_word(10'd2), 1'b1, '{48'd2, 1'b0, 10'd0, 1'b0, 1'b0,
                       48'd4, 48'd2, 11'd0, 11'd2}});
      rows.push_back('{access_word(64'hAAAA_AAAA_AAAA_AAAA, 31'h2AAA_AAAA), 1'b0, '0});
      rows.push_back('{access_word(64'h5555_5555_5555_5555, 31'h5555_5555), 1'b0, '0});
      rows.push_back('{read_word(10'h2AA), 1'b0, '0});
      rows.push_back('{read_word(10'h155), 1'b0, '0});
      for (int i = 0; i < 130; i += 16)
         rows.push_back('{access_word(64'h5555_5555_5555_5555, 31'(i)), 1'b0, '0});
      foreach (rows[i]) send_word(rows[i].w, rows[i].fixed, rows[i].e);

      // fine sampling, narrowest groups
      write_settings(17'd1, 17'd1, 17'(access_count) + 17'd1);
      run_random(150, 15, 40);

      // sample every access with fresh keys until the table overflows
      write_settings(17'd0, 17'd2, 17'(access_count) + 17'd1);
      drops = 0;
      for (int n = 0; drops < 8; n++) begin
         if (occ == OCC_LIMIT) drops++;
         send_word(access_word({8'hF1, 24'd0, 32'(n)}, {30'($urandom), 1'b0}), 1'b0, '0);
      end

      // groups of 256, sparse samples, drain the full table
      write_settings(17'd65535, 17'd256, 17'd131071);
      run_random(150, 15, 80);

      write_settings(17'd3, 17'd0, 17'(access_count) + 17'd1);
      run_random(150, 15, 50);

      // sample position already behind the counter
      write_settings(17'd16, 17'h1FF, 17'd0);
      run_random(100, 20, 60);

      wait_idle();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
